@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the bcpc_checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked while reset is released.
`define CHK_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Property checked on every edge, reset included.
`define CHK_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("assertion failed");

`endif

@@ rtl/bcpc_pkg.sv @@
// ----------------------------------------------------------------------------
// bcpc_pkg
// Shared constants of the buoy color pixel classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package bcpc_pkg;

  localparam int PIX_W    = 8;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W    = 8;

  // Fixed-point HSV
  localparam int HSV_SHIFT   = 12;
  localparam int SAT_RECIP_N = 255 << HSV_SHIFT;
  localparam int HUE_RECIP_N = (180 << HSV_SHIFT) / 6;
  localparam int SAT_RECIP_W = 20;
  localparam int HUE_RECIP_W = 17;
  localparam int HUE_NUM_W   = 12;
  localparam int HUE_W       = 10;
  localparam int HUE_FULL    = 180;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LAB_MODE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHROMA_LAB    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHROMA_SEA    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VALUE_MIN     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WATER_HUE_LO  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WATER_HUE_HI  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_WATER_SAT_MIN = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_WATER_VAL_MIN = 3'd7;

  // Register reset values
  localparam logic             RST_LAB_MODE      = 1'b1;
  localparam logic [PIX_W-1:0] RST_CHROMA_LAB    = 8'd60;
  localparam logic [PIX_W-1:0] RST_CHROMA_SEA    = 8'd20;
  localparam logic [PIX_W-1:0] RST_VALUE_MIN     = 8'd40;
  localparam logic [PIX_W-1:0] RST_WATER_HUE_LO  = 8'd90;
  localparam logic [PIX_W-1:0] RST_WATER_HUE_HI  = 8'd135;
  localparam logic [PIX_W-1:0] RST_WATER_SAT_MIN = 8'd80;
  localparam logic [PIX_W-1:0] RST_WATER_VAL_MIN = 8'd30;

endpackage

`default_nettype wire

@@ rtl/buoy_color_pixel_classifier_core.sv @@
// ----------------------------------------------------------------------------
// buoy_color_pixel_classifier_core
// Per-pixel HSV water test and red/green chroma dominance masks.
// ----------------------------------------------------------------------------
// One BGR pixel is taken per clock while in_ready is high and passes four
// register stages; the output register releases it on the first edge with
// out_ready high. Stage 1 finds max, min, channel leads and the hue sector
// numerator, stage 2 reads the two reciprocal tables, stage 3 does the two
// multiplies, and the output register holds rounding, range compares and mode
// gating. Each stage holds its item when the next one is stalled, so an output
// stall only stops the input once every stage is occupied. Configuration
// writes take effect at once; the user must make them while idle (unenforced).
`default_nettype none

module buoy_color_pixel_classifier_core (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_wr_en,
  input  wire logic [bcpc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [bcpc_pkg::CFG_W-1:0]     cfg_data,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [bcpc_pkg::PIX_W-1:0]     in_pixel_blue,
  input  wire logic [bcpc_pkg::PIX_W-1:0]     in_pixel_green,
  input  wire logic [bcpc_pkg::PIX_W-1:0]     in_pixel_red,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic                                out_red_buoy,
  output logic                                out_green_buoy,
  output logic                                out_water
);

  localparam int PW  = bcpc_pkg::PIX_W;
  localparam int SRW = bcpc_pkg::SAT_RECIP_W;
  localparam int HRW = bcpc_pkg::HUE_RECIP_W;
  localparam int HNW = bcpc_pkg::HUE_NUM_W;
  localparam int HW  = bcpc_pkg::HUE_W;
  localparam int SH  = bcpc_pkg::HSV_SHIFT;
  localparam int SPW = PW + SRW;
  localparam int HPW = HNW + HRW + 1;
  localparam int SW  = PW + 1;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic          lab_mode_r;
  logic [PW-1:0] chroma_lab_r, chroma_sea_r, value_min_r;
  logic [PW-1:0] hue_lo_r, hue_hi_r, sat_min_r, val_min_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lab_mode_r   <= bcpc_pkg::RST_LAB_MODE;
      chroma_lab_r <= bcpc_pkg::RST_CHROMA_LAB;
      chroma_sea_r <= bcpc_pkg::RST_CHROMA_SEA;
      value_min_r  <= bcpc_pkg::RST_VALUE_MIN;
      hue_lo_r     <= bcpc_pkg::RST_WATER_HUE_LO;
      hue_hi_r     <= bcpc_pkg::RST_WATER_HUE_HI;
      sat_min_r    <= bcpc_pkg::RST_WATER_SAT_MIN;
      val_min_r    <= bcpc_pkg::RST_WATER_VAL_MIN;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        bcpc_pkg::REG_LAB_MODE:      lab_mode_r   <= cfg_data[0];
        bcpc_pkg::REG_CHROMA_LAB:    chroma_lab_r <= cfg_data[PW-1:0];
        bcpc_pkg::REG_CHROMA_SEA:    chroma_sea_r <= cfg_data[PW-1:0];
        bcpc_pkg::REG_VALUE_MIN:     value_min_r  <= cfg_data[PW-1:0];
        bcpc_pkg::REG_WATER_HUE_LO:  hue_lo_r     <= cfg_data[PW-1:0];
        bcpc_pkg::REG_WATER_HUE_HI:  hue_hi_r     <= cfg_data[PW-1:0];
        bcpc_pkg::REG_WATER_SAT_MIN: sat_min_r    <= cfg_data[PW-1:0];
        bcpc_pkg::REG_WATER_VAL_MIN: val_min_r    <= cfg_data[PW-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Reciprocal tables, rounded to nearest, ties to even; zero at index zero
  // --------------------------------------------------------------------------
  logic [SRW-1:0] sat_recip [2**PW];
  logic [HRW-1:0] hue_recip [2**PW];

  for (genvar i = 0; i < 2**PW; i++) begin : g_recip
    localparam int D  = (i == 0) ? 1 : i;
    localparam int SQ = bcpc_pkg::SAT_RECIP_N / D;
    localparam int SR = bcpc_pkg::SAT_RECIP_N % D;
    localparam int HQ = bcpc_pkg::HUE_RECIP_N / D;
    localparam int HR = bcpc_pkg::HUE_RECIP_N % D;
    localparam int SV = (i == 0) ? 0 :
      SQ + (((2 * SR > D) || ((2 * SR == D) && (SQ % 2 == 1))) ? 1 : 0);
    localparam int HV = (i == 0) ? 0 :
      HQ + (((2 * HR > D) || ((2 * HR == D) && (HQ % 2 == 1))) ? 1 : 0);
    assign sat_recip[i] = SRW'(SV);
    assign hue_recip[i] = HRW'(HV);
  end

  // --------------------------------------------------------------------------
  // Stage handshake
  // --------------------------------------------------------------------------
  logic s1_valid_r, s2_valid_r, s3_valid_r, out_valid_r;
  logic out_load, rdy3, rdy2, rdy1;

  assign out_load = !out_valid_r || out_ready;
  assign rdy3     = !s3_valid_r || out_load;
  assign rdy2     = !s2_valid_r || rdy3;
  assign rdy1     = !s1_valid_r || rdy2;
  assign in_ready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (rdy1)     s1_valid_r  <= in_valid;
      if (rdy2)     s2_valid_r  <= s1_valid_r;
      if (rdy3)     s3_valid_r  <= s2_valid_r;
      if (out_load) out_valid_r <= s3_valid_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: max, min, leads, hue numerator
  // --------------------------------------------------------------------------
  logic [PW-1:0]         vmax, vmin, maxo_gb, maxo_rb;
  logic [PW-1:0]         red_dom_nxt, green_dom_nxt;
  logic signed [HNW-1:0] bs, gs, rs, diffs, hnum_nxt;

  always_comb begin
    vmax = (in_pixel_red > in_pixel_green) ? in_pixel_red : in_pixel_green;
    if (in_pixel_blue > vmax) vmax = in_pixel_blue;
    vmin = (in_pixel_red < in_pixel_green) ? in_pixel_red : in_pixel_green;
    if (in_pixel_blue < vmin) vmin = in_pixel_blue;

    maxo_gb = (in_pixel_green > in_pixel_blue) ? in_pixel_green : in_pixel_blue;
    maxo_rb = (in_pixel_red > in_pixel_blue) ? in_pixel_red : in_pixel_blue;
    red_dom_nxt   = (in_pixel_red > maxo_gb) ? in_pixel_red - maxo_gb : '0;
    green_dom_nxt = (in_pixel_green > maxo_rb) ? in_pixel_green - maxo_rb : '0;

    bs    = $signed(HNW'(in_pixel_blue));
    gs    = $signed(HNW'(in_pixel_green));
    rs    = $signed(HNW'(in_pixel_red));
    diffs = $signed(HNW'(vmax - vmin));
    priority if (vmax == in_pixel_red) begin
      hnum_nxt = gs - bs;
    end else if (vmax == in_pixel_green) begin
      hnum_nxt = bs - rs + (diffs <<< 1);
    end else begin
      hnum_nxt = rs - gs + (diffs <<< 2);
    end
  end

  logic [PW-1:0]         s1_v_r, s1_diff_r, s1_rdom_r, s1_gdom_r;
  logic signed [HNW-1:0] s1_hnum_r;

  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_v_r    <= vmax;
      s1_diff_r <= vmax - vmin;
      s1_rdom_r <= red_dom_nxt;
      s1_gdom_r <= green_dom_nxt;
      s1_hnum_r <= hnum_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: reciprocal lookup
  // --------------------------------------------------------------------------
  logic [PW-1:0]         s2_v_r, s2_diff_r, s2_rdom_r, s2_gdom_r;
  logic signed [HNW-1:0] s2_hnum_r;
  logic [SRW-1:0]        s2_srec_r;
  logic [HRW-1:0]        s2_hrec_r;

  always_ff @(posedge clk) begin
    if (rdy2) begin
      s2_v_r    <= s1_v_r;
      s2_diff_r <= s1_diff_r;
      s2_rdom_r <= s1_rdom_r;
      s2_gdom_r <= s1_gdom_r;
      s2_hnum_r <= s1_hnum_r;
      s2_srec_r <= sat_recip[s1_v_r];
      s2_hrec_r <= hue_recip[s1_diff_r];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: products
  // --------------------------------------------------------------------------
  logic [PW-1:0]         s3_v_r, s3_rdom_r, s3_gdom_r;
  logic [SPW-1:0]        s3_sprod_r;
  logic signed [HPW-1:0] s3_hprod_r;

  always_ff @(posedge clk) begin
    if (rdy3) begin
      s3_v_r     <= s2_v_r;
      s3_rdom_r  <= s2_rdom_r;
      s3_gdom_r  <= s2_gdom_r;
      s3_sprod_r <= SPW'(s2_diff_r) * SPW'(s2_srec_r);
      s3_hprod_r <= HPW'(s2_hnum_r) * $signed(HPW'(s2_hrec_r));
    end
  end

  // --------------------------------------------------------------------------
  // Output stage: rounding, range tests, gating
  // --------------------------------------------------------------------------
  logic [SPW-1:0]        sat_sum;
  logic [SW-1:0]         sat;
  logic signed [HPW-1:0] hue_sum;
  logic signed [HW-1:0]  hue_raw, hue;
  logic [PW-1:0]         thr;
  logic                  water_nxt, vok, red_nxt, green_nxt;

  always_comb begin
    sat_sum = s3_sprod_r + SPW'(1 << (SH - 1));
    sat     = sat_sum[SH+SW-1:SH];
    hue_sum = s3_hprod_r + HPW'(1 << (SH - 1));
    hue_raw = HW'(hue_sum >>> SH);
    hue     = (hue_raw < 0) ? hue_raw + HW'(bcpc_pkg::HUE_FULL) : hue_raw;

    water_nxt = (hue >= $signed(HW'(hue_lo_r))) && (hue <= $signed(HW'(hue_hi_r))) &&
                (sat >= SW'(sat_min_r)) && (s3_v_r >= val_min_r);
    vok       = s3_v_r > value_min_r;
    thr       = lab_mode_r ? chroma_lab_r : chroma_sea_r;
    red_nxt   = vok && (s3_rdom_r > thr) && (lab_mode_r || !water_nxt);
    green_nxt = vok && (s3_gdom_r > thr) && (lab_mode_r || !water_nxt);
  end

  logic out_red_r, out_green_r, out_water_r;

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_red_r   <= red_nxt;
      out_green_r <= green_nxt;
      out_water_r <= water_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_red_buoy   = out_red_r;
  assign out_green_buoy = out_green_r;
  assign out_water      = out_water_r;

endmodule

`default_nettype wire

@@ rtl/bcpc_checker.sv @@
// ----------------------------------------------------------------------------
// bcpc_checker
// Port-level checks of the buoy color pixel classifier core.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module bcpc_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic out_red_buoy,
  input wire logic out_green_buoy,
  input wire logic out_water
);

  logic [2:0] out_fields;

  assign out_fields = {out_red_buoy, out_green_buoy, out_water};

  // reset empties the pipeline
  `CHK_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid)

  // a channel cannot lead both other channels at once
  `CHK_ASSERT(a_masks_exclusive, clk, rst_n, out_valid |-> !(out_red_buoy && out_green_buoy))

  // with no result pending every stage can advance
  `CHK_ASSERT(a_ready_when_drained, clk, rst_n, !out_valid |-> in_ready)

  // a stalled result holds until its transfer
  `CHK_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_fields))

endmodule

bind buoy_color_pixel_classifier_core bcpc_checker u_bcpc_checker (.*);

`default_nettype wire

@@ sim/buoy_mask_checker.sv @@
// ----------------------------------------------------------------------------
// buoy_mask_checker
// Predicts and checks the red/green/water masks of the pixel classifier.
// ----------------------------------------------------------------------------
// Mirrors every register write, predicts the masks of each pixel taken on the
// input channel and compares each result transfer, field by field, with the
// oldest prediction. The mismatch count and the number of pixels still
// waiting for a result go to the testbench top.
`timescale 1ns / 1ps

module buoy_mask_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [bcpc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bcpc_pkg::CFG_W-1:0]     cfg_data,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic [bcpc_pkg::PIX_W-1:0]     in_pixel_blue,
  input  logic [bcpc_pkg::PIX_W-1:0]     in_pixel_green,
  input  logic [bcpc_pkg::PIX_W-1:0]     in_pixel_red,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic                           out_red_buoy,
  input  logic                           out_green_buoy,
  input  logic                           out_water,
  output int                             mismatch_count,
  output int                             masks_outstanding
);

  typedef struct packed {
    logic red;
    logic green;
    logic water;
  } masks_t;

  typedef struct packed {
    logic                       lab_mode;
    logic [bcpc_pkg::PIX_W-1:0] chroma_lab;
    logic [bcpc_pkg::PIX_W-1:0] chroma_sea;
    logic [bcpc_pkg::PIX_W-1:0] value_min;
    logic [bcpc_pkg::PIX_W-1:0] hue_lo;
    logic [bcpc_pkg::PIX_W-1:0] hue_hi;
    logic [bcpc_pkg::PIX_W-1:0] sat_min;
    logic [bcpc_pkg::PIX_W-1:0] val_min;
  } settings_t;

  settings_t settings;
  masks_t    pending_masks[$];
  int        result_idx = 0;

  initial begin
    mismatch_count    = 0;
    masks_outstanding = 0;
  end

  // Nearest integer quotient, ties to even; zero divisor gives zero.
  function automatic longint recip_even(input longint num, input longint den);
    longint q;
    longint rem;
    if (den == 0) return 0;
    q   = num / den;
    rem = num % den;
    if (2 * rem > den || (2 * rem == den && q % 2 == 1)) q++;
    return q;
  endfunction

  // Round half up, then floor to Q0.
  function automatic longint round_q12(input longint x);
    return (x + (longint'(1) << (bcpc_pkg::HSV_SHIFT - 1))) >>> bcpc_pkg::HSV_SHIFT;
  endfunction

  function automatic masks_t classify_pixel(input settings_t cs,
                                            input logic [bcpc_pkg::PIX_W-1:0] b_in,
                                            input logic [bcpc_pkg::PIX_W-1:0] g_in,
                                            input logic [bcpc_pkg::PIX_W-1:0] r_in);
    longint bv, gv, rv;
    longint vmax, vmin, spread, sat, hue, lead_r, lead_g, thr;
    masks_t m;
    bv = longint'(b_in);
    gv = longint'(g_in);
    rv = longint'(r_in);
    vmax = rv > gv ? rv : gv;
    if (bv > vmax) vmax = bv;
    vmin = rv < gv ? rv : gv;
    if (bv < vmin) vmin = bv;
    spread = vmax - vmin;

    sat = round_q12(spread * recip_even(longint'(bcpc_pkg::SAT_RECIP_N), vmax));

    if (vmax == rv) hue = gv - bv;
    else if (vmax == gv) hue = bv - rv + 2 * spread;
    else hue = rv - gv + 4 * spread;
    hue = round_q12(hue * recip_even(longint'(bcpc_pkg::HUE_RECIP_N), spread));
    if (hue < 0) hue += longint'(bcpc_pkg::HUE_FULL);

    m.water = hue >= longint'(cs.hue_lo) && hue <= longint'(cs.hue_hi) &&
              sat >= longint'(cs.sat_min) && vmax >= longint'(cs.val_min);

    thr    = cs.lab_mode ? longint'(cs.chroma_lab) : longint'(cs.chroma_sea);
    lead_r = rv - (gv > bv ? gv : bv);
    lead_g = gv - (rv > bv ? rv : bv);
    if (lead_r < 0) lead_r = 0;
    if (lead_g < 0) lead_g = 0;
    m.red   = vmax > longint'(cs.value_min) && lead_r > thr;
    m.green = vmax > longint'(cs.value_min) && lead_g > thr;

    if (!cs.lab_mode && m.water) begin
      m.red   = 1'b0;
      m.green = 1'b0;
    end
    return m;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch at result %0d: %s", $time, result_idx, msg);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    masks_t got;
    masks_t want;
    if (!rst_n) begin
      settings.lab_mode   = bcpc_pkg::RST_LAB_MODE;
      settings.chroma_lab = bcpc_pkg::RST_CHROMA_LAB;
      settings.chroma_sea = bcpc_pkg::RST_CHROMA_SEA;
      settings.value_min  = bcpc_pkg::RST_VALUE_MIN;
      settings.hue_lo     = bcpc_pkg::RST_WATER_HUE_LO;
      settings.hue_hi     = bcpc_pkg::RST_WATER_HUE_HI;
      settings.sat_min    = bcpc_pkg::RST_WATER_SAT_MIN;
      settings.val_min    = bcpc_pkg::RST_WATER_VAL_MIN;
      pending_masks.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          bcpc_pkg::REG_LAB_MODE:      settings.lab_mode   = cfg_data[0];
          bcpc_pkg::REG_CHROMA_LAB:    settings.chroma_lab = cfg_data;
          bcpc_pkg::REG_CHROMA_SEA:    settings.chroma_sea = cfg_data;
          bcpc_pkg::REG_VALUE_MIN:     settings.value_min  = cfg_data;
          bcpc_pkg::REG_WATER_HUE_LO:  settings.hue_lo     = cfg_data;
          bcpc_pkg::REG_WATER_HUE_HI:  settings.hue_hi     = cfg_data;
          bcpc_pkg::REG_WATER_SAT_MIN: settings.sat_min    = cfg_data;
          bcpc_pkg::REG_WATER_VAL_MIN: settings.val_min    = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        pending_masks = {pending_masks,
                         classify_pixel(settings, in_pixel_blue,
                                        in_pixel_green, in_pixel_red)};
      if (out_valid && out_ready) begin
        got.red   = out_red_buoy;
        got.green = out_green_buoy;
        got.water = out_water;
        if (pending_masks.size() == 0) begin
          report_mismatch("result transfer with no pixel pending");
        end else begin
          want = pending_masks.pop_front();
          if (got.red !== want.red)
            report_mismatch($sformatf("red_buoy got %b want %b", got.red, want.red));
          if (got.green !== want.green)
            report_mismatch($sformatf("green_buoy got %b want %b", got.green,
                                      want.green));
          if (got.water !== want.water)
            report_mismatch($sformatf("water got %b want %b", got.water, want.water));
        end
        result_idx++;
      end
    end
    masks_outstanding = pending_masks.size();
  end

endmodule

@@ sim/tb_buoy_color_pixel_classifier_core.sv @@
// ----------------------------------------------------------------------------
// tb_buoy_color_pixel_classifier_core
// Stimulus and verdict for the buoy color pixel classifier.
// ----------------------------------------------------------------------------
// Sends corner pixels at reset settings, then several register settings
// (sea and lab mode, all-min, all-max, empty and out-of-range hue windows,
// random) each with a random mix of water-like, dominant, gray, tied and
// near-threshold pixels. Both channels idle in random bursts; one long
// output hold-off fills the pipeline. The checker does the comparing.
`timescale 1ns / 1ps

module tb_buoy_color_pixel_classifier_core;

  localparam int PW  = bcpc_pkg::PIX_W;
  localparam int CW  = bcpc_pkg::CFG_W;
  localparam int CIW = bcpc_pkg::CFG_IDX_W;

  localparam int CYCLE_LIMIT     = 300000;
  localparam int PHASES          = 7;
  localparam int PIXELS_PER_PHASE = 200;
  localparam int SQUEEZE_PIXELS  = 60;
  localparam int SQUEEZE_CYCLES  = 48;

  typedef struct packed {
    logic [PW-1:0] b;
    logic [PW-1:0] g;
    logic [PW-1:0] r;
  } pixel_t;

  typedef struct packed {
    logic [CW-1:0] lab_mode;
    logic [CW-1:0] chroma_lab;
    logic [CW-1:0] chroma_sea;
    logic [CW-1:0] value_min;
    logic [CW-1:0] hue_lo;
    logic [CW-1:0] hue_hi;
    logic [CW-1:0] sat_min;
    logic [CW-1:0] val_min;
  } reg_image_t;

  logic           clk = 1'b0;
  logic           rst_n;
  logic           cfg_wr_en;
  logic [CIW-1:0] cfg_index;
  logic [CW-1:0]  cfg_data;
  logic           in_valid;
  logic           in_ready;
  logic [PW-1:0]  in_pixel_blue;
  logic [PW-1:0]  in_pixel_green;
  logic [PW-1:0]  in_pixel_red;
  logic           out_valid;
  logic           out_ready;
  logic           out_red_buoy;
  logic           out_green_buoy;
  logic           out_water;
  int             mismatch_count;
  int             masks_outstanding;

  logic           calm = 1'b0;
  logic           squeeze = 1'b0;
  logic [CW-1:0]  cur_thr;
  int             cycles = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  buoy_color_pixel_classifier_core dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_pixel_blue  (in_pixel_blue),
    .in_pixel_green (in_pixel_green),
    .in_pixel_red   (in_pixel_red),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_red_buoy   (out_red_buoy),
    .out_green_buoy (out_green_buoy),
    .out_water      (out_water)
  );

  buoy_mask_checker u_mask_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_pixel_blue     (in_pixel_blue),
    .in_pixel_green    (in_pixel_green),
    .in_pixel_red      (in_pixel_red),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_red_buoy      (out_red_buoy),
    .out_green_buoy    (out_green_buoy),
    .out_water         (out_water),
    .mismatch_count    (mismatch_count),
    .masks_outstanding (masks_outstanding)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAILURE");
      $finish;
    end
  end

  // Result side: random stall bursts, one long hold-off while squeezed.
  int  gap_left = 0;
  int  hold_left = 0;
  bit  squeeze_done = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (squeeze && !squeeze_done) begin
      squeeze_done <= 1'b1;
      hold_left    <= SQUEEZE_CYCLES - 1;
      out_ready    <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (calm) begin
      out_ready <= 1'b1;
    end else if (gap_left != 0) begin
      gap_left  <= gap_left - 1;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      gap_left  <= int'($urandom_range(1, 8)) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic offer_pixel(input pixel_t px);
    in_valid       <= 1'b1;
    in_pixel_blue  <= px.b;
    in_pixel_green <= px.g;
    in_pixel_red   <= px.r;
    do @(posedge clk); while (!in_ready);
    if (!calm && !squeeze && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  task automatic write_setting(input logic [CIW-1:0] idx,
                               input logic [CW-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic apply_settings(input reg_image_t ri);
    in_valid <= 1'b0;
    @(posedge clk);
    while (masks_outstanding != 0) @(posedge clk);
    write_setting(bcpc_pkg::REG_LAB_MODE,      ri.lab_mode);
    write_setting(bcpc_pkg::REG_CHROMA_LAB,    ri.chroma_lab);
    write_setting(bcpc_pkg::REG_CHROMA_SEA,    ri.chroma_sea);
    write_setting(bcpc_pkg::REG_VALUE_MIN,     ri.value_min);
    write_setting(bcpc_pkg::REG_WATER_HUE_LO,  ri.hue_lo);
    write_setting(bcpc_pkg::REG_WATER_HUE_HI,  ri.hue_hi);
    write_setting(bcpc_pkg::REG_WATER_SAT_MIN, ri.sat_min);
    write_setting(bcpc_pkg::REG_WATER_VAL_MIN, ri.val_min);
    cfg_wr_en <= 1'b0;
    cur_thr = ri.lab_mode[0] ? ri.chroma_lab : ri.chroma_sea;
  endtask

  function automatic reg_image_t phase_settings(input int p);
    reg_image_t ri;
    // upper bits of lab_mode are don't-care
    ri.lab_mode = {7'($urandom_range(0, 127)), 1'b0};
    case (p)
      0: begin   // sea mode, default windows
        ri.chroma_lab = 8'd60;  ri.chroma_sea = 8'd20;  ri.value_min = 8'd40;
        ri.hue_lo     = 8'd90;  ri.hue_hi     = 8'd135; ri.sat_min   = 8'd80;
        ri.val_min    = 8'd30;
      end
      1: begin   // everything open, hue window past 179
        ri.chroma_lab = 8'd0;   ri.chroma_sea = 8'd0;   ri.value_min = 8'd0;
        ri.hue_lo     = 8'd0;   ri.hue_hi     = 8'd255; ri.sat_min   = 8'd0;
        ri.val_min    = 8'd0;
      end
      2: begin   // lab mode, everything at max
        ri.lab_mode[0] = 1'b1;
        ri.chroma_lab = 8'd255; ri.chroma_sea = 8'd255; ri.value_min = 8'd255;
        ri.hue_lo     = 8'd255; ri.hue_hi     = 8'd255; ri.sat_min   = 8'd255;
        ri.val_min    = 8'd255;
      end
      3: begin   // empty hue window
        ri.chroma_lab = 8'd30;  ri.chroma_sea = 8'd10;  ri.value_min = 8'd20;
        ri.hue_lo     = 8'd150; ri.hue_hi     = 8'd100; ri.sat_min   = 8'd40;
        ri.val_min    = 8'd20;
      end
      default: begin
        ri.lab_mode   = 8'($urandom_range(0, 255));
        ri.chroma_lab = 8'($urandom_range(0, 100));
        ri.chroma_sea = 8'($urandom_range(0, 60));
        ri.value_min  = 8'($urandom_range(0, 120));
        ri.hue_lo     = 8'($urandom_range(0, 170));
        ri.hue_hi     = $urandom_range(0, 4) == 0 ? 8'($urandom_range(0, 255))
                                                  : 8'($urandom_range(ri.hue_lo, 200));
        ri.sat_min    = 8'($urandom_range(0, 200));
        ri.val_min    = 8'($urandom_range(0, 150));
      end
    endcase
    return ri;
  endfunction

  function automatic pixel_t random_pixel(input logic [CW-1:0] thr);
    pixel_t px;
    int     top;
    int     base;
    int     lead;
    px = 24'($urandom);
    case ($urandom_range(0, 9))
      2, 3: begin   // water-like: blue on top
        top  = int'($urandom_range(40, 255));
        px.b = 8'(top);
        px.g = 8'($urandom_range(0, top));
        px.r = 8'($urandom_range(0, top / 2));
      end
      4: begin
        top  = int'($urandom_range(30, 255));
        px.r = 8'(top);
        px.g = 8'($urandom_range(0, top));
        px.b = 8'($urandom_range(0, top));
      end
      5: begin
        top  = int'($urandom_range(30, 255));
        px.g = 8'(top);
        px.r = 8'($urandom_range(0, top));
        px.b = 8'($urandom_range(0, top));
      end
      6: begin   // gray
        px.r = 8'($urandom_range(0, 255));
        px.g = px.r;
        px.b = px.r;
      end
      7: begin   // two channels tied on top
        top  = int'($urandom_range(0, 255));
        base = int'($urandom_range(0, top));
        case ($urandom_range(0, 2))
          0: px = {8'(base), 8'(top), 8'(top)};
          1: px = {8'(top), 8'(top), 8'(base)};
          default: px = {8'(top), 8'(base), 8'(top)};
        endcase
      end
      8: begin   // chroma lead around the threshold
        base = int'($urandom_range(0, 150));
        lead = int'(thr) + int'($urandom_range(0, 2)) - 1;
        if (lead < 0) lead = 0;
        top = base + lead;
        if (top > 255) top = 255;
        if ($urandom_range(0, 1) == 0) px = {8'($urandom_range(0, base)), 8'(base), 8'(top)};
        else px = {8'($urandom_range(0, base)), 8'(top), 8'(base)};
      end
      9: begin   // dim
        px.r = 8'($urandom_range(0, 64));
        px.g = 8'($urandom_range(0, 64));
        px.b = 8'($urandom_range(0, 64));
      end
      default: ;
    endcase
    return px;
  endfunction

  initial begin
    rst_n          <= 1'b0;
    cfg_wr_en      <= 1'b0;
    cfg_index      <= bcpc_pkg::REG_LAB_MODE;
    cfg_data       <= '0;
    in_valid       <= 1'b0;
    in_pixel_blue  <= '0;
    in_pixel_green <= '0;
    in_pixel_red   <= '0;
    cur_thr         = bcpc_pkg::RST_CHROMA_LAB;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // corner pixels at reset settings, fields in b, g, r order
    offer_pixel({8'd0,   8'd0,   8'd0});     // black
    offer_pixel({8'd255, 8'd255, 8'd255});   // white
    offer_pixel({8'd128, 8'd128, 8'd128});   // gray
    offer_pixel({8'd0,   8'd0,   8'd255});
    offer_pixel({8'd0,   8'd255, 8'd0});
    offer_pixel({8'd255, 8'd0,   8'd0});
    offer_pixel({8'd0,   8'd255, 8'd255});   // red/green tie
    offer_pixel({8'd255, 8'd255, 8'd0});     // green/blue tie
    offer_pixel({8'd255, 8'd0,   8'd255});   // red/blue tie
    offer_pixel({8'd200, 8'd200, 8'd0});     // hue at window low edge
    offer_pixel({8'd255, 8'd0,   8'd128});   // hue at window high edge
    offer_pixel({8'd255, 8'd0,   8'd134});   // just past it
    offer_pixel({8'd10,  8'd0,   8'd255});   // negative hue wraps
    offer_pixel({8'd0,   8'd40,  8'd100});   // red lead equals threshold
    offer_pixel({8'd0,   8'd40,  8'd101});
    offer_pixel({8'd40,  8'd101, 8'd0});
    offer_pixel({8'd255, 8'd175, 8'd175});   // saturation at minimum
    offer_pixel({8'd255, 8'd176, 8'd176});
    offer_pixel({8'd30,  8'd0,   8'd0});     // value at water minimum
    offer_pixel({8'd29,  8'd0,   8'd0});
    offer_pixel({8'd0,   8'd0,   8'd1});
    offer_pixel({8'd1,   8'd0,   8'd0});
    offer_pixel({8'd64,  8'd64,  8'd65});

    for (int p = 0; p < PHASES; p++) begin
      apply_settings(phase_settings(p));
      calm = (p == PHASES - 1);
      for (int k = 0; k < PIXELS_PER_PHASE; k++) begin
        squeeze = (p == 0 && k < SQUEEZE_PIXELS);
        offer_pixel(random_pixel(cur_thr));
      end
      squeeze = 1'b0;
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (masks_outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && masks_outstanding == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/bcpc_pkg.sv
rtl/buoy_color_pixel_classifier_core.sv
rtl/bcpc_checker.sv
sim/buoy_mask_checker.sv
sim/tb_buoy_color_pixel_classifier_core.sv
